[hw/rtl/sqlt_pkg.sv]
`timescale 1ns / 1ps

package sqlt_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 64;
  localparam int MAX_TEXT_LEN_DEF  = 4096;

  // Result queue depth; an item may add two results.
  localparam int FIFO_DEPTH = 4;

  localparam logic [3:0] KIND_IDENT   = 4'd0;
  localparam logic [3:0] KIND_KEYWORD = 4'd1;
  localparam logic [3:0] KIND_INT     = 4'd2;
  localparam logic [3:0] KIND_STRING  = 4'd3;
  localparam logic [3:0] KIND_OPER    = 4'd4;
  localparam logic [3:0] KIND_LPAREN  = 4'd5;
  localparam logic [3:0] KIND_RPAREN  = 4'd6;
  localparam logic [3:0] KIND_COMMA   = 4'd7;
  localparam logic [3:0] KIND_SEMI    = 4'd8;
  localparam logic [3:0] KIND_STAR    = 4'd9;
  localparam logic [3:0] KIND_END     = 4'd10;
  localparam logic [3:0] KIND_ERROR   = 4'd11;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd1;
  localparam logic [2:0] ERR_UNTERM_STR = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN    = 3'd3;
  localparam logic [2:0] ERR_BAD_SIGN   = 3'd4;
  localparam logic [2:0] ERR_TEXT_LONG  = 3'd5;

  localparam logic [2:0] OP_EQ = 3'd0;
  localparam logic [2:0] OP_NE = 3'd4;

  localparam int NUM_KW = 6;

  // Keyword spellings, upper case, padded with zero bytes.
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"I", "N", "S", "E", "R", "T", 8'h00, 8'h00},
    '{"I", "N", "T", "O", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"V", "A", "L", "U", "E", "S", 8'h00, 8'h00},
    '{"S", "E", "L", "E", "C", "T", 8'h00, 8'h00},
    '{"F", "R", "O", "M", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"W", "H", "E", "R", "E", 8'h00, 8'h00, 8'h00}
  };
  localparam int KW_LEN [NUM_KW] = '{6, 4, 6, 6, 4, 5};

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  kw_code;
    logic [2:0]  op_code;
    logic [11:0] start;
    logic [5:0]  len;
    logic [11:0] total;
    logic [2:0]  err;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

[hw/rtl/sqlt_lexer.sv]
`timescale 1ns / 1ps

module sqlt_lexer import sqlt_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
  parameter int MAX_TEXT_LEN  = MAX_TEXT_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_en_i,
  input  logic [7:0] text_byte_i,
  input  logic       terminator_i,
  output push_t      push_o
);

  localparam int PW = $clog2(MAX_TEXT_LEN) + 1;
  localparam int CW = $clog2(MAX_TOKEN_LEN);

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_IDENT  = 3'd1;
  localparam logic [2:0] M_NUMBER = 3'd2;
  localparam logic [2:0] M_SIGN   = 3'd3;
  localparam logic [2:0] M_STRING = 3'd4;
  localparam logic [2:0] M_OPER   = 3'd5;
  localparam logic [2:0] M_ERROR  = 3'd6;

  logic [2:0]        mode_q, mode_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [PW-1:0]     start_q, start_d;
  logic [CW-1:0]     chars_q, chars_d;
  logic [NUM_KW-1:0] cand_q, cand_d;
  logic [1:0]        pend_q, pend_d;
  logic [11:0]       count_q, count_d;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [NUM_KW-1:0] kw_match(input logic [2:0] idx, input logic [7:0] u);
    logic [NUM_KW-1:0] m;
    for (int k = 0; k < NUM_KW; k++) begin
      m[k] = (KW_TEXT[k][idx] == u);
    end
    return m;
  endfunction

  function automatic result_t mk(input logic [3:0] kind, input logic [2:0] kw,
                                 input logic [2:0] op, input logic [PW-1:0] start,
                                 input logic [CW-1:0] len, input logic [2:0] err);
    result_t r;
    r.kind    = kind;
    r.kw_code = kw;
    r.op_code = op;
    r.start   = 12'(start);
    r.len     = 6'(len);
    r.total   = '0;
    r.err     = err;
    r.last    = 1'b0;
    return r;
  endfunction

  logic [7:0]        c, u;
  logic              full;
  logic [NUM_KW-1:0] wm_cur, wm0;

  assign c      = text_byte_i;
  assign u      = (c >= "a" && c <= "z") ? c - 8'd32 : c;
  assign full   = chars_q >= CW'(MAX_TOKEN_LEN - 1);
  // Bytes past the longest keyword match nothing.
  assign wm_cur = (int'(chars_q) < 8) ? kw_match(chars_q[2:0], u) : '0;
  assign wm0    = kw_match(3'd0, u);

  // Start of a new token from the current byte.
  logic              b_v, b_tok;
  result_t           b_r;
  logic [2:0]        b_mode;
  logic [PW-1:0]     b_start;
  logic [CW-1:0]     b_chars;
  logic [NUM_KW-1:0] b_cand;
  logic [1:0]        b_pend;

  always_comb begin
    b_v     = 1'b0;
    b_tok   = 1'b0;
    b_r     = '0;
    b_mode  = M_IDLE;
    b_start = start_q;
    b_chars = chars_q;
    b_cand  = cand_q;
    b_pend  = pend_q;
    if (!is_space(c)) begin
      unique case (c)
        "'": begin
          b_mode  = M_STRING;
          b_start = pos_q + PW'(1);
          b_chars = '0;
        end
        "(": begin
          b_v = 1'b1; b_tok = 1'b1;
          b_r = mk(KIND_LPAREN, 3'd0, 3'd0, pos_q, CW'(1), ERR_NONE);
        end
        ")": begin
          b_v = 1'b1; b_tok = 1'b1;
          b_r = mk(KIND_RPAREN, 3'd0, 3'd0, pos_q, CW'(1), ERR_NONE);
        end
        ",": begin
          b_v = 1'b1; b_tok = 1'b1;
          b_r = mk(KIND_COMMA, 3'd0, 3'd0, pos_q, CW'(1), ERR_NONE);
        end
        ";": begin
          b_v = 1'b1; b_tok = 1'b1;
          b_r = mk(KIND_SEMI, 3'd0, 3'd0, pos_q, CW'(1), ERR_NONE);
        end
        "*": begin
          b_v = 1'b1; b_tok = 1'b1;
          b_r = mk(KIND_STAR, 3'd0, 3'd0, pos_q, CW'(1), ERR_NONE);
        end
        "=": begin
          b_v = 1'b1; b_tok = 1'b1;
          b_r = mk(KIND_OPER, 3'd0, OP_EQ, pos_q, CW'(1), ERR_NONE);
        end
        "!": begin
          b_mode = M_OPER; b_pend = 2'd0; b_start = pos_q;
        end
        "<": begin
          b_mode = M_OPER; b_pend = 2'd1; b_start = pos_q;
        end
        ">": begin
          b_mode = M_OPER; b_pend = 2'd2; b_start = pos_q;
        end
        "+", "-": begin
          b_mode = M_SIGN; b_start = pos_q; b_chars = CW'(1);
        end
        default: begin
          if (is_digit(c)) begin
            b_mode = M_NUMBER; b_start = pos_q; b_chars = CW'(1);
          end else if (is_alpha(c) || c == "_") begin
            b_mode = M_IDENT; b_start = pos_q; b_chars = CW'(1);
            b_cand = wm0;
          end else begin
            b_v    = 1'b1;
            b_r    = mk(KIND_ERROR, 3'd0, 3'd0, pos_q, '0, ERR_UNKNOWN);
            b_mode = M_ERROR;
          end
        end
      endcase
    end
  end

  // Close the pending token.
  logic    f_v, f_found;
  result_t f_r;

  always_comb begin
    f_v     = 1'b0;
    f_found = 1'b0;
    f_r     = '0;
    unique case (mode_q)
      M_IDENT: begin
        f_v = 1'b1;
        f_r = mk(KIND_IDENT, 3'd0, 3'd0, start_q, chars_q, ERR_NONE);
        for (int k = 0; k < NUM_KW; k++) begin
          if (!f_found && cand_q[k] && int'(chars_q) == KW_LEN[k]) begin
            f_found = 1'b1;
            f_r     = mk(KIND_KEYWORD, 3'(k), 3'd0, start_q, chars_q, ERR_NONE);
          end
        end
      end
      M_NUMBER: begin
        f_v = 1'b1;
        f_r = mk(KIND_INT, 3'd0, 3'd0, start_q, chars_q, ERR_NONE);
      end
      M_OPER: begin
        f_v = 1'b1;
        f_r = mk(KIND_OPER, 3'd0, 3'(pend_q) + 3'd1, start_q, CW'(1), ERR_NONE);
      end
      default: ;
    endcase
  end

  logic        v0, v1, t0, t1, fb;
  result_t     r0, r1;
  logic [12:0] end_sum, cnt_sum;

  assign end_sum = {1'b0, count_q} + 13'(f_v);

  always_comb begin
    v0 = 1'b0; v1 = 1'b0; t0 = 1'b0; t1 = 1'b0; fb = 1'b0;
    r0 = '0;   r1 = '0;
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    chars_d = chars_q;
    cand_d  = cand_q;
    pend_d  = pend_q;
    if (terminator_i) begin
      if (mode_q == M_STRING) begin
        v0 = 1'b1;
        r0 = mk(KIND_ERROR, 3'd0, 3'd0, start_q, '0, ERR_UNTERM_STR);
      end else if (mode_q == M_SIGN) begin
        v0 = 1'b1;
        r0 = mk(KIND_ERROR, 3'd0, 3'd0, start_q, '0, ERR_BAD_SIGN);
      end else if (mode_q != M_ERROR) begin
        v0 = f_v; t0 = f_v; r0 = f_r;
        v1 = 1'b1;
        r1 = mk(KIND_END, 3'd0, 3'd0, pos_q, '0, ERR_NONE);
        r1.total = end_sum[12] ? 12'hFFF : end_sum[11:0];
      end
      mode_d  = M_IDLE;
      pos_d   = '0;
      start_d = '0;
      chars_d = '0;
      cand_d  = '1;
      pend_d  = '0;
    end else if (mode_q != M_ERROR) begin
      if (pos_q >= PW'(MAX_TEXT_LEN)) begin
        v0     = 1'b1;
        r0     = mk(KIND_ERROR, 3'd0, 3'd0, pos_q, '0, ERR_TEXT_LONG);
        mode_d = M_ERROR;
      end else begin
        pos_d = pos_q + PW'(1);
        unique case (mode_q)
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == "_") begin
              if (full) begin
                v0 = 1'b1; mode_d = M_ERROR;
                r0 = mk(KIND_ERROR, 3'd0, 3'd0, start_q, '0, ERR_TOO_LONG);
              end else begin
                chars_d = chars_q + CW'(1);
                cand_d  = cand_q & wm_cur;
              end
            end else begin
              fb = 1'b1;
            end
          end
          M_NUMBER: begin
            if (is_digit(c)) begin
              if (full) begin
                v0 = 1'b1; mode_d = M_ERROR;
                r0 = mk(KIND_ERROR, 3'd0, 3'd0, start_q, '0, ERR_TOO_LONG);
              end else begin
                chars_d = chars_q + CW'(1);
              end
            end else begin
              fb = 1'b1;
            end
          end
          M_SIGN: begin
            v0 = 1'b1; mode_d = M_ERROR;
            if (!is_digit(c)) begin
              r0 = mk(KIND_ERROR, 3'd0, 3'd0, start_q, '0, ERR_BAD_SIGN);
            end else if (full) begin
              r0 = mk(KIND_ERROR, 3'd0, 3'd0, start_q, '0, ERR_TOO_LONG);
            end else begin
              v0      = 1'b0;
              mode_d  = M_NUMBER;
              chars_d = chars_q + CW'(1);
            end
          end
          M_STRING: begin
            if (c == "'") begin
              v0 = 1'b1; t0 = 1'b1; mode_d = M_IDLE;
              r0 = mk(KIND_STRING, 3'd0, 3'd0, start_q, chars_q, ERR_NONE);
            end else if (full) begin
              v0 = 1'b1; mode_d = M_ERROR;
              r0 = mk(KIND_ERROR, 3'd0, 3'd0, start_q, '0, ERR_TOO_LONG);
            end else begin
              chars_d = chars_q + CW'(1);
            end
          end
          M_OPER: begin
            if (c == "=") begin
              v0 = 1'b1; t0 = 1'b1; mode_d = M_IDLE;
              r0 = mk(KIND_OPER, 3'd0, 3'(pend_q) + OP_NE, start_q, CW'(2), ERR_NONE);
            end else begin
              fb = 1'b1;
            end
          end
          default: begin
            v0 = b_v; t0 = b_tok; r0 = b_r;
            mode_d  = b_mode;
            start_d = b_start;
            chars_d = b_chars;
            cand_d  = b_cand;
            pend_d  = b_pend;
          end
        endcase
        if (fb) begin
          v0 = f_v; t0 = f_v;   r0 = f_r;
          v1 = b_v; t1 = b_tok; r1 = b_r;
          mode_d  = b_mode;
          start_d = b_start;
          chars_d = b_chars;
          cand_d  = b_cand;
          pend_d  = b_pend;
        end
      end
    end
  end

  // Token count saturates at the field's top value.
  assign cnt_sum = {1'b0, count_q} + 13'(t0) + 13'(t1);
  assign count_d = terminator_i ? 12'd0 : (cnt_sum[12] ? 12'hFFF : cnt_sum[11:0]);

  // Pack results to the front and mark the final one.
  always_comb begin
    push_o = '0;
    if (step_en_i) begin
      if (v0) begin
        push_o.r0 = r0;
        push_o.r1 = r1;
        push_o.n  = v1 ? 2'd2 : 2'd1;
      end else begin
        push_o.r0 = r1;
        push_o.n  = v1 ? 2'd1 : 2'd0;
      end
      push_o.r0.last = (push_o.n == 2'd1);
      push_o.r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      chars_q <= '0;
      cand_q  <= '1;
      pend_q  <= '0;
      count_q <= '0;
    end else if (step_en_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      chars_q <= chars_d;
      cand_q  <= cand_d;
      pend_q  <= pend_d;
      count_q <= count_d;
    end
  end

endmodule

[hw/rtl/sqlt_fifo.sv]
`timescale 1ns / 1ps

module sqlt_fifo import sqlt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output logic    room2_o,
  output logic    valid_o,
  output result_t head_o
);

  localparam int AW = $clog2(FIFO_DEPTH);

  result_t       mem [FIFO_DEPTH];
  logic [AW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic [AW-1:0] wr_p1;

  assign wr_p1   = wr_q + AW'(1);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem[rd_q];
  assign room2_o = cnt_q <= (AW + 1)'(FIFO_DEPTH - 2);

  assign rd_d  = pop_i ? rd_q + AW'(1) : rd_q;
  assign wr_d  = wr_q + AW'(push_i.n);
  assign cnt_d = cnt_q + (AW + 1)'(push_i.n) - (AW + 1)'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem[wr_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[hw/rtl/sql_statement_tokenizer.sv]
`timescale 1ns / 1ps
// Streaming SQL tokenizer. Feed statement text one byte per transfer on the
// input channel (in_valid_i / in_stall_o), with terminator_i set on a final
// transfer that flushes the pending token, emits the end token with the
// token count and clears the lexer for the next statement.
// Each byte yields zero, one or two tokens on the output channel
// (out_valid_o / out_stall_i); last_of_run_o marks the final token of a byte.
// After an error token, bytes are dropped until the terminator, which then emits
// no end token; an open string or sign ends in an error token instead. A byte
// is staged in a register, lexed once the queue has room and its tokens queued.
// Throughput: one byte per cycle while the queue keeps room for two results;
// tokens leave one at a time, and the four-entry result queue sets how far
// input runs ahead before in_stall_o rises.
// When the receiver stalls, the shown token holds and the queue fills; input
// stalls once fewer than two free entries remain.
// Reset clears the lexer state and empties the queue; no clearing pass.
module sql_statement_tokenizer import sqlt_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
  parameter int MAX_TEXT_LEN  = MAX_TEXT_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        terminator_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [2:0]  keyword_code_o,
  output logic [2:0]  operator_code_o,
  output logic [11:0] start_offset_o,
  output logic [5:0]  token_length_o,
  output logic [11:0] token_total_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_run_o
);

  logic       st_valid_q, st_valid_d;
  logic [7:0] st_byte_q;
  logic       st_term_q;
  logic       room2, go, accept;
  push_t      push;
  result_t    head;

  assign go         = st_valid_q && room2;
  assign in_stall_o = st_valid_q && !room2;
  assign accept     = in_valid_i && !in_stall_o;
  assign st_valid_d = accept || (st_valid_q && !go);

  sqlt_lexer #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (go),
    .text_byte_i (st_byte_q),
    .terminator_i(st_term_q),
    .push_o      (push)
  );

  sqlt_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (out_valid_o && !out_stall_i),
    .room2_o(room2),
    .valid_o(out_valid_o),
    .head_o (head)
  );

  assign token_kind_o    = head.kind;
  assign keyword_code_o  = head.kw_code;
  assign operator_code_o = head.op_code;
  assign start_offset_o  = head.start;
  assign token_length_o  = head.len;
  assign token_total_o   = head.total;
  assign error_code_o    = head.err;
  assign last_of_run_o   = head.last;

  // Hold the staged byte until the queue has room for its results.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_byte_q <= text_byte_i;
      st_term_q <= terminator_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
    end
  end

endmodule
